// File: src/csalu_pkg.sv
// Shared types and codes for the checked signed ALU.
package csalu_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned WIDTH_DEF = 64;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_REM = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  // Control word that travels down the chain next to the data.
  typedef struct packed {
    logic       vld;
    logic [2:0] act;
    logic       neg_a;
    logic       neg_q;
    logic       fast_ovf;
    logic       div0;
  } ctl_t;

endpackage

// File: src/csalu_cell.sv
// One stage of the chain: one step of the shift-add multiply and of the
// restoring divide, applied to the beat held in this cell.
module csalu_cell #(
  parameter int unsigned WIDTH = csalu_pkg::WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  csalu_pkg::ctl_t        ctl_in,
  input  logic [WIDTH-1:0]       acc_in,
  input  logic [WIDTH-1:0]       mq_in,
  input  logic [WIDTH-1:0]       mb_in,
  input  logic [WIDTH-1:0]       fast_in,
  output csalu_pkg::ctl_t        ctl_out,
  output logic [WIDTH-1:0]       acc_out,
  output logic [WIDTH-1:0]       mq_out,
  output logic [WIDTH-1:0]       mb_out,
  output logic [WIDTH-1:0]       fast_out
);
  import csalu_pkg::*;

  ctl_t             ctl_r;
  logic [WIDTH-1:0] acc_r, mq_r, mb_r, fast_r;
  logic [WIDTH-1:0] acc_nxt, mq_nxt;
  logic [WIDTH:0]   sum, trial;

  // Multiply consumes one multiplier bit from the bottom of mq; the product
  // shifts right through acc into mq. Divide shifts one dividend bit in.
  always_comb begin
    acc_nxt = acc_in;
    mq_nxt  = mq_in;
    sum     = {1'b0, acc_in} + (mq_in[0] ? {1'b0, mb_in} : '0);
    trial   = {acc_in, mq_in[WIDTH-1]} - {1'b0, mb_in};
    if (ctl_in.act == ACT_MUL) begin
      acc_nxt = sum[WIDTH:1];
      mq_nxt  = {sum[0], mq_in[WIDTH-1:1]};
    end else if (ctl_in.act == ACT_DIV || ctl_in.act == ACT_REM) begin
      if (!trial[WIDTH]) begin
        acc_nxt = trial[WIDTH-1:0];
        mq_nxt  = {mq_in[WIDTH-2:0], 1'b1};
      end else begin
        acc_nxt = {acc_in[WIDTH-2:0], mq_in[WIDTH-1]};
        mq_nxt  = {mq_in[WIDTH-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
    acc_r  <= acc_nxt;
    mq_r   <= mq_nxt;
    mb_r   <= mb_in;
    fast_r <= fast_in;
  end

  assign ctl_out  = ctl_r;
  assign acc_out  = acc_r;
  assign mq_out   = mq_r;
  assign mb_out   = mb_r;
  assign fast_out = fast_r;

endmodule

// File: src/checked_signed_alu_core.sv
// Top level of the overflow-checked signed ALU.
// One beat enters per clock while busy stays low; busy is always low. Every
// operation, add and subtract included, passes through the input register,
// the chain of WIDTH cells that perform one multiply or divide step each,
// and the output register. out_valid pulses for one clock per beat in issue
// order, and the receiver cannot stall the result.
module checked_signed_alu_core #(
  parameter int unsigned WIDTH = csalu_pkg::WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_action,
  input  logic signed [csalu_pkg::DATA_W-1:0] in_operand_a,
  input  logic signed [csalu_pkg::DATA_W-1:0] in_operand_b,
  output logic                          out_valid,
  output logic signed [csalu_pkg::DATA_W-1:0] out_value,
  output logic [1:0]                    out_status
);
  import csalu_pkg::*;

  logic [WIDTH-1:0] a, b, ma, mb, sum_w, dif_w;
  logic             na, nb;
  ctl_t             ctl0;
  logic [WIDTH-1:0] fast0;

  assign busy = 1'b0;
  assign a  = in_operand_a[WIDTH-1:0];
  assign b  = in_operand_b[WIDTH-1:0];
  assign na = a[WIDTH-1];
  assign nb = b[WIDTH-1];
  assign ma = na ? (~a + 1'b1) : a;
  assign mb = nb ? (~b + 1'b1) : b;
  assign sum_w = a + b;
  assign dif_w = a - b;

  // Front end: classify the beat and resolve add and subtract directly.
  always_comb begin
    ctl0          = '0;
    ctl0.vld      = start;
    ctl0.act      = in_action;
    ctl0.neg_a    = na;
    ctl0.neg_q    = na ^ nb;
    fast0         = '0;
    case (in_action)
      ACT_ADD: begin
        ctl0.fast_ovf = (na == nb) && (sum_w[WIDTH-1] != na);
        fast0 = sum_w;
      end
      ACT_SUB: begin
        ctl0.fast_ovf = (na != nb) && (dif_w[WIDTH-1] != na);
        fast0 = dif_w;
      end
      ACT_DIV, ACT_REM: begin
        ctl0.div0 = (b == '0);
      end
      default: begin
      end
    endcase
  end

  ctl_t             ctl_c [WIDTH+1];
  logic [WIDTH-1:0] acc_c [WIDTH+1];
  logic [WIDTH-1:0] mq_c  [WIDTH+1];
  logic [WIDTH-1:0] mb_c  [WIDTH+1];
  logic [WIDTH-1:0] fst_c [WIDTH+1];

  // Input register feeding the first cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_c[0] <= '0;
    end else begin
      ctl_c[0] <= ctl0;
    end
    acc_c[0] <= '0;
    mq_c[0]  <= ma;
    mb_c[0]  <= mb;
    fst_c[0] <= fast0;
  end

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    csalu_cell #(.WIDTH(WIDTH)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .ctl_in(ctl_c[i]), .acc_in(acc_c[i]), .mq_in(mq_c[i]), .mb_in(mb_c[i]),
      .fast_in(fst_c[i]),
      .ctl_out(ctl_c[i+1]), .acc_out(acc_c[i+1]), .mq_out(mq_c[i+1]),
      .mb_out(mb_c[i+1]), .fast_out(fst_c[i+1])
    );
  end

  // Back end: sign, range check and status.
  ctl_t             ce;
  logic [WIDTH-1:0] hi_w, lo_w, mag, res_w, rm;
  logic             ovf;
  logic [1:0]       st;
  logic             val_r;
  logic [DATA_W-1:0] val_out_r;
  logic [1:0]       st_r;

  assign ce   = ctl_c[WIDTH];
  assign hi_w = acc_c[WIDTH];
  assign lo_w = mq_c[WIDTH];

  always_comb begin
    ovf   = 1'b0;
    res_w = '0;
    st    = ST_OK;
    mag   = lo_w;
    rm    = acc_c[WIDTH];
    case (ce.act)
      ACT_ADD, ACT_SUB: begin
        ovf   = ce.fast_ovf;
        res_w = fst_c[WIDTH];
      end
      ACT_MUL, ACT_DIV: begin
        if (ce.act == ACT_MUL && hi_w != '0) begin
          ovf = 1'b1;
        end else if (ce.neg_q) begin
          ovf   = mag[WIDTH-1] && (mag[WIDTH-2:0] != '0);
          res_w = ~mag + 1'b1;
        end else begin
          ovf   = mag[WIDTH-1];
          res_w = mag;
        end
      end
      ACT_REM: begin
        res_w = (ce.neg_a && rm != '0) ? (mb_c[WIDTH] - rm) : rm;
      end
      default: begin
      end
    endcase
    if (ce.div0 && (ce.act == ACT_DIV || ce.act == ACT_REM)) begin
      st = ST_DIV0;
    end else if (ovf) begin
      st = ST_OVF;
    end
    if (st != ST_OK) begin
      res_w = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= 1'b0;
    end else begin
      val_r <= ce.vld;
    end
    val_out_r <= (ce.act == ACT_REM)
               ? {{(DATA_W-WIDTH){1'b0}}, res_w}
               : {{(DATA_W-WIDTH){res_w[WIDTH-1]}}, res_w};
    st_r <= st;
  end

  assign out_valid  = val_r;
  assign out_value  = val_out_r;
  assign out_status = st_r;

endmodule

// File: src/csalu_checker.sv
// Port-level checker for the checked signed ALU, bound to the top level.
module csalu_checker #(
  parameter int unsigned WIDTH = csalu_pkg::WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [63:0] out_value,
  input logic [1:0]  out_status
);
  import csalu_pkg::*;

  // Every beat returns exactly one result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(WIDTH+2) out_valid) else $error("lost result");
  a_nospur: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, WIDTH+2)) else $error("spurious result");
  // Error results carry a zero value.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_value == '0) else $error("nonzero on error");
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("bad status");

endmodule

bind checked_signed_alu_core csalu_checker #(.WIDTH(WIDTH)) u_csalu_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_value(out_value), .out_status(out_status)
);

// File: bench/testbench.sv
// Self-checking testbench for the overflow-checked signed ALU core.
module testbench;
  import csalu_pkg::*;

  localparam int unsigned LATENCY = WIDTH_DEF + 2;
  localparam int N_RANDOM = 1750;
  localparam longint CYCLE_LIMIT = 200000;

  typedef struct {
    logic [2:0]  act;
    logic [63:0] a;
    logic [63:0] b;
    logic        known;
    logic [63:0] value;
    status_t     status;
  } stim_row_t;

  typedef struct {
    logic [63:0] value;
    status_t     status;
  } alu_result_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [2:0] in_action;
  logic signed [63:0] in_operand_a;
  logic signed [63:0] in_operand_b;
  logic out_valid;
  logic signed [63:0] out_value;
  logic [1:0] out_status;

  alu_result_t pending_results[$];
  int errors;
  int beats_in;
  int beats_out;
  longint cycles;
  stim_row_t rows[$];

  checked_signed_alu_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_value(out_value), .out_status(out_status)
  );

  // Free-running clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Computes the exact result of one operation on 64-bit signed operands.
  function automatic alu_result_t compute_alu(logic [2:0] act, logic [63:0] a,
                                              logic [63:0] b);
    alu_result_t r;
    logic signed [129:0] wa, wb, w;
    logic [63:0] ma, mb, rm;
    begin
      r.value = '0;
      r.status = ST_OK;
      wa = $signed(a);
      wb = $signed(b);
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      w = '0;
      case (act)
        ACT_ADD: w = wa + wb;
        ACT_SUB: w = wa - wb;
        ACT_MUL: w = wa * wb;
        ACT_DIV: begin
          if (b == 0) r.status = ST_DIV0;
          else begin
            w = $signed({66'd0, ma / mb});
            if (a[63] != b[63]) w = -w;
          end
        end
        ACT_REM: begin
          if (b == 0) r.status = ST_DIV0;
          else begin
            rm = ma % mb;
            if (a[63] && rm != 0) rm = mb - rm;
            w = $signed({66'd0, rm});
          end
        end
        default: w = '0;
      endcase
      if (r.status == ST_OK) begin
        if (w > 130'sh7FFFFFFFFFFFFFFF || w < -130'sh8000000000000000)
          r.status = ST_OVF;
        else r.value = w[63:0];
      end
      return r;
    end
  endfunction

  function automatic logic [63:0] random_operand();
    logic [63:0] v;
    begin
      v = {$urandom, $urandom};
      case ($urandom_range(0, 7))
        0: v = 64'h8000000000000000 + $urandom_range(0, 3);
        1: v = 64'h7FFFFFFFFFFFFFFF - $urandom_range(0, 3);
        2: v = 64'($signed($urandom_range(0, 3)) - 2);
        3: v = {{32{v[31]}}, v[31:0]};
        4: v = {{48{v[15]}}, v[15:0]};
        default: ;
      endcase
      return v;
    end
  endfunction

  // Result checker: compares every strobed beat with the oldest expectation.
  always @(posedge clk) begin
    alu_result_t exp_r;
    if (rst_n && out_valid) begin
      beats_out <= beats_out + 1;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%h status=%0d", $time, out_value,
                 out_status);
        errors <= errors + 1;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_value !== exp_r.value || out_status !== exp_r.status) begin
          $display("%0t: mismatch expected value=%h status=%0d actual value=%h status=%0d",
                   $time, exp_r.value, exp_r.status, out_value, out_status);
          errors <= errors + 1;
        end
      end
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Drives one beat and waits until it is accepted.
  task automatic send_beat(logic [2:0] act, logic [63:0] a, logic [63:0] b,
                           logic known, logic [63:0] value, status_t status);
    alu_result_t r;
    int gap;
    begin
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) begin
        start <= 1'b0;
        @(negedge clk);
      end
      r = compute_alu(act, a, b);
      if (known) begin
        r.value = value;
        r.status = status;
      end
      start <= 1'b1;
      in_action <= act;
      in_operand_a <= a;
      in_operand_b <= b;
      do @(posedge clk); while (busy);
      pending_results.push_back(r);
      beats_in++;
      @(negedge clk);
    end
  endtask

  localparam logic [63:0] MAXV = 64'h7FFFFFFFFFFFFFFF;
  localparam logic [63:0] MINV = 64'h8000000000000000;
  localparam logic [63:0] NEG1 = 64'hFFFFFFFFFFFFFFFF;

  initial begin
    stim_row_t row;
    logic [2:0] act;
    logic [63:0] a, b;
    errors = 0;
    beats_in = 0;
    beats_out = 0;
    cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_action = '0;
    in_operand_a = '0;
    in_operand_b = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed table; rows with known set carry their expected result.
    rows.push_back('{ACT_ADD, MAXV, 64'd1, 1, 64'd0, ST_OVF});
    rows.push_back('{ACT_ADD, MINV, NEG1, 1, 64'd0, ST_OVF});
    rows.push_back('{ACT_ADD, MAXV, MINV, 1, NEG1, ST_OK});
    rows.push_back('{ACT_SUB, 64'd0, MINV, 1, 64'd0, ST_OVF});
    rows.push_back('{ACT_SUB, NEG1, MINV, 1, MAXV, ST_OK});
    rows.push_back('{ACT_SUB, MINV, 64'd1, 1, 64'd0, ST_OVF});
    rows.push_back('{ACT_MUL, MINV, 64'd0, 1, 64'd0, ST_OK});
    rows.push_back('{ACT_MUL, 64'd0, MINV, 1, 64'd0, ST_OK});
    rows.push_back('{ACT_MUL, MINV, NEG1, 1, 64'd0, ST_OVF});
    rows.push_back('{ACT_MUL, MINV, 64'd1, 1, MINV, ST_OK});
    rows.push_back('{ACT_MUL, 64'h100000000, 64'hFFFFFFFF80000000, 0, 0, ST_OK});
    rows.push_back('{ACT_MUL, MAXV, MAXV, 1, 64'd0, ST_OVF});
    rows.push_back('{ACT_DIV, MINV, NEG1, 1, 64'd0, ST_OVF});
    rows.push_back('{ACT_DIV, 64'd5, 64'd0, 1, 64'd0, ST_DIV0});
    rows.push_back('{ACT_DIV, -64'sd7, 64'd2, 1, -64'sd3, ST_OK});
    rows.push_back('{ACT_DIV, MINV, MINV, 1, 64'd1, ST_OK});
    rows.push_back('{ACT_REM, 64'd5, 64'd0, 1, 64'd0, ST_DIV0});
    rows.push_back('{ACT_REM, -64'sd7, 64'd2, 1, 64'd1, ST_OK});
    rows.push_back('{ACT_REM, -64'sd7, -64'sd2, 1, 64'd1, ST_OK});
    rows.push_back('{ACT_REM, NEG1, MINV, 1, MAXV, ST_OK});
    rows.push_back('{ACT_REM, MINV, NEG1, 1, 64'd0, ST_OK});
    rows.push_back('{3'd5, MAXV, MAXV, 1, 64'd0, ST_OK});
    rows.push_back('{3'd6, MINV, NEG1, 1, 64'd0, ST_OK});
    rows.push_back('{3'd7, NEG1, 64'd0, 1, 64'd0, ST_OK});
    foreach (rows[i]) begin
      row = rows[i];
      send_beat(row.act, row.a, row.b, row.known, row.value, row.status);
    end

    // Random beats, mostly valid actions with edge-heavy operands.
    repeat (N_RANDOM) begin
      act = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
      a = random_operand();
      b = random_operand();
      send_beat(act, a, b, 1'b0, '0, ST_OK);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    $display("Sent %0d beats (all actions, operand extremes, random data); checked %0d results.",
             beats_in, beats_out);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
